### design/ifs_pkg.sv
package ifs_pkg;

  localparam int unsigned PIXEL_W    = 8;
  localparam int unsigned FWIDTH_W   = 10;
  localparam int unsigned FHEIGHT_W  = 9;
  localparam int unsigned THRESH_W   = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned ASYM_W     = 9;
  localparam int unsigned CONTRAST_W = 18;
  localparam int unsigned LONGEST_W  = 9;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONTRAST_THRESHOLD = 2'd2;

  localparam logic [FWIDTH_W-1:0]  FRAME_WIDTH_RESET  = 10'd320;
  localparam logic [FHEIGHT_W-1:0] FRAME_HEIGHT_RESET = 9'd200;
  localparam logic [THRESH_W-1:0]  THRESHOLD_RESET    = 8'd128;
  localparam logic [PIXEL_W-1:0]   DARKEST_RESET      = 8'd255;
  localparam logic [PIXEL_W-1:0]   BRIGHTEST_RESET    = 8'd0;

  typedef struct packed {
    logic restart;
    logic first_col;
    logic last_col;
    logic first_row;
    logic last_row;
    logic mirror_active;
    logic mirror_self;
  } ifs_pos_t;

  function automatic logic beyond(input logic [PIXEL_W-1:0] a, input logic [PIXEL_W-1:0] b,
                                  input logic [THRESH_W-1:0] t);
    logic [PIXEL_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d > t;
  endfunction

endpackage

### design/ifs_scan.sv
module ifs_scan #(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_HEIGHT = 256,
  localparam int unsigned CW  = $clog2(MAX_WIDTH),
  localparam int unsigned WCW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned HCW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              frame_start_i,
  input  logic [WCW-1:0]    width_i,
  input  logic [HCW-1:0]    height_i,
  output logic [CW-1:0]     x_o,
  output logic [CW-1:0]     mirror_o,
  output ifs_pkg::ifs_pos_t pos_o
);
  import ifs_pkg::*;

  localparam int unsigned RCW = $clog2(MAX_HEIGHT);

  logic [CW-1:0]  col_q, col_d;
  logic [RCW-1:0] row_q, row_d;
  logic [CW-1:0]  x;
  logic [RCW-1:0] y;
  logic           restart;

  always_comb begin
    restart = frame_start_i || (WCW'(col_q) >= width_i) || (HCW'(row_q) >= height_i);
    x = restart ? '0 : col_q;
    y = restart ? '0 : row_q;
    mirror_o = CW'(width_i - WCW'(1) - WCW'(x));
    pos_o.restart       = restart;
    pos_o.first_col     = (x == '0);
    pos_o.last_col      = (WCW'(x) == width_i - WCW'(1));
    pos_o.first_row     = (y == '0);
    pos_o.last_row      = (HCW'(y) == height_i - HCW'(1));
    pos_o.mirror_active = (WCW'(x) >= (width_i >> 1));
    pos_o.mirror_self   = (mirror_o == x);
    x_o = x;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (pos_o.last_col) begin
        col_d = '0;
        row_d = pos_o.last_row ? '0 : y + RCW'(1);
      end else begin
        col_d = x + CW'(1);
        row_d = y;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

### design/ifs_line_store.sv
module ifs_line_store #(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_HEIGHT = 256,
  localparam int unsigned CW = $clog2(MAX_WIDTH),
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [CW-1:0]               rd_x_i,
  input  logic [CW-1:0]               rd_m_i,
  input  logic                        wr_en_i,
  input  logic [CW-1:0]               wr_x_i,
  input  logic [ifs_pkg::PIXEL_W-1:0] wr_pixel_i,
  input  logic [RW-1:0]               wr_run_i,
  input  logic                        mk_wr_en_i,
  input  logic [CW-1:0]               mk_wr_addr_i,
  input  logic                        mk_wr_mark_i,
  output logic [ifs_pkg::PIXEL_W-1:0] pixel_x_o,
  output logic [RW-1:0]               run_x_o,
  output logic [ifs_pkg::PIXEL_W-1:0] pixel_m_o,
  output logic                        mark_x_o
);
  import ifs_pkg::*;

  logic [PIXEL_W-1:0] pix_mem  [MAX_WIDTH];
  logic [RW-1:0]      run_mem  [MAX_WIDTH];
  logic               mark_mem [MAX_WIDTH];

  logic [PIXEL_W-1:0] pix_x_q, pix_m_q, byp_pix_q;
  logic [RW-1:0]      run_x_q, byp_run_q;
  logic               mark_x_q, byp_mark_q;
  logic               byp_x_q, byp_m_q, byp_mk_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      pix_mem[wr_x_i] <= wr_pixel_i;
      run_mem[wr_x_i] <= wr_run_i;
    end
    if (mk_wr_en_i) begin
      mark_mem[mk_wr_addr_i] <= mk_wr_mark_i;
    end
    if (rd_en_i) begin
      pix_x_q    <= pix_mem[rd_x_i];
      run_x_q    <= run_mem[rd_x_i];
      pix_m_q    <= pix_mem[rd_m_i];
      mark_x_q   <= mark_mem[rd_x_i];
      byp_pix_q  <= wr_pixel_i;
      byp_run_q  <= wr_run_i;
      byp_mark_q <= mk_wr_mark_i;
    end
  end

  // A write in the same cycle as a read of that entry is forwarded to the reader.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_x_q  <= 1'b0;
      byp_m_q  <= 1'b0;
      byp_mk_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_x_q  <= wr_en_i && (wr_x_i == rd_x_i);
      byp_m_q  <= wr_en_i && (wr_x_i == rd_m_i);
      byp_mk_q <= mk_wr_en_i && (mk_wr_addr_i == rd_x_i);
    end
  end

  assign pixel_x_o = byp_x_q ? byp_pix_q : pix_x_q;
  assign run_x_o   = byp_x_q ? byp_run_q : run_x_q;
  assign pixel_m_o = byp_m_q ? byp_pix_q : pix_m_q;
  assign mark_x_o  = byp_mk_q ? byp_mark_q : mark_x_q;

endmodule

### design/ifs_stats.sv
module ifs_stats #(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_HEIGHT = 256,
  localparam int unsigned CW = $clog2(MAX_WIDTH),
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic [CW-1:0]                  x_i,
  input  logic [ifs_pkg::PIXEL_W-1:0]    pixel_i,
  input  ifs_pkg::ifs_pos_t              pos_i,
  input  logic [ifs_pkg::THRESH_W-1:0]   threshold_i,
  input  logic [ifs_pkg::PIXEL_W-1:0]    pixel_above_i,
  input  logic [RW-1:0]                  run_above_i,
  input  logic [ifs_pkg::PIXEL_W-1:0]    pixel_mirror_i,
  input  logic                           mark_above_i,
  output logic                           ready_o,
  output logic                           wr_en_o,
  output logic [CW-1:0]                  wr_x_o,
  output logic [ifs_pkg::PIXEL_W-1:0]    wr_pixel_o,
  output logic [RW-1:0]                  wr_run_o,
  output logic                           mk_wr_en_o,
  output logic [CW-1:0]                  mk_wr_addr_o,
  output logic                           mk_wr_mark_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ifs_pkg::PIXEL_W-1:0]    darkest_o,
  output logic [ifs_pkg::PIXEL_W-1:0]    brightest_o,
  output logic [ifs_pkg::ASYM_W-1:0]     asymmetric_rows_o,
  output logic [ifs_pkg::CONTRAST_W-1:0] contrast_pixels_o,
  output logic [ifs_pkg::LONGEST_W-1:0]  longest_vertical_run_o
);
  import ifs_pkg::*;

  logic               valid_q;
  logic [CW-1:0]      x_q;
  logic [PIXEL_W-1:0] v_q;
  ifs_pos_t           pos_q;

  logic [PIXEL_W-1:0]    dark_q, bright_q, left_pixel_q;
  logic                  seen_q, left_mark_q, last_mark_q;
  logic [ASYM_W-1:0]     mis_q;
  logic [CONTRAST_W-1:0] cnt_q;
  logic [RW-1:0]         long_q;

  logic [PIXEL_W-1:0]    res_dark_q, res_bright_q;
  logic [ASYM_W-1:0]     res_mis_q;
  logic [CONTRAST_W-1:0] res_cnt_q;
  logic [LONGEST_W-1:0]  res_long_q;
  logic                  out_valid_q;

  logic [PIXEL_W-1:0]    base_dark, base_bright, dark_d, bright_d, mirror_v;
  logic                  base_seen, seen_d;
  logic [ASYM_W-1:0]     base_mis, mis_d;
  logic [CONTRAST_W-1:0] base_cnt, cnt_d;
  logic [RW-1:0]         base_long, long_d, run;
  logic                  dl, da, mark_above, lm, cur, inc_above, inc_left, inc_cur;
  logic                  emit, fire;

  always_comb begin
    base_dark   = pos_q.restart ? DARKEST_RESET : dark_q;
    base_bright = pos_q.restart ? BRIGHTEST_RESET : bright_q;
    base_seen   = pos_q.restart ? 1'b0 : seen_q;
    base_mis    = pos_q.restart ? '0 : mis_q;
    base_cnt    = pos_q.restart ? '0 : cnt_q;
    base_long   = pos_q.restart ? RW'(1) : long_q;

    dl = !pos_q.first_col && beyond(v_q, left_pixel_q, threshold_i);
    da = !pos_q.first_row && beyond(v_q, pixel_above_i, threshold_i);
    mark_above = pos_q.last_col ? last_mark_q : mark_above_i;
    lm  = left_mark_q || dl;
    cur = dl || da;
    inc_above = !pos_q.first_row && (mark_above || da);
    inc_left  = !pos_q.first_col && pos_q.last_row && lm;
    inc_cur   = pos_q.last_col && pos_q.last_row && cur;
    cnt_d = base_cnt + CONTRAST_W'(inc_above) + CONTRAST_W'(inc_left) + CONTRAST_W'(inc_cur);

    mirror_v = pos_q.mirror_self ? v_q : pixel_mirror_i;
    seen_d = base_seen;
    mis_d  = base_mis;
    if (pos_q.mirror_active && !base_seen && (mirror_v != v_q)) begin
      seen_d = 1'b1;
      mis_d  = base_mis + ASYM_W'(1);
    end

    run = (!pos_q.first_row && (pixel_above_i == v_q)) ? run_above_i + RW'(1) : RW'(1);
    long_d = (run > base_long) ? run : base_long;

    dark_d   = (v_q < base_dark) ? v_q : base_dark;
    bright_d = (v_q > base_bright) ? v_q : base_bright;

    emit    = valid_q && pos_q.last_col && pos_q.last_row;
    ready_o = !valid_q || !emit || !out_valid_q || out_ready_i;
    fire    = valid_q && ready_o;
  end

  assign wr_en_o      = fire;
  assign wr_x_o       = x_q;
  assign wr_pixel_o   = v_q;
  assign wr_run_o     = run;
  assign mk_wr_en_o   = fire && !pos_q.first_col;
  assign mk_wr_addr_o = x_q - CW'(1);
  assign mk_wr_mark_o = lm;

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      x_q   <= x_i;
      v_q   <= pixel_i;
      pos_q <= pos_i;
    end
    if (fire) begin
      left_pixel_q <= v_q;
      if (pos_q.last_col) begin
        last_mark_q <= cur;
      end
    end
    if (fire && emit) begin
      res_dark_q   <= dark_d;
      res_bright_q <= bright_d;
      res_mis_q    <= mis_d;
      res_cnt_q    <= cnt_d;
      res_long_q   <= LONGEST_W'(long_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      out_valid_q <= 1'b0;
      dark_q      <= DARKEST_RESET;
      bright_q    <= BRIGHTEST_RESET;
      seen_q      <= 1'b0;
      mis_q       <= '0;
      cnt_q       <= '0;
      long_q      <= RW'(1);
      left_mark_q <= 1'b0;
    end else begin
      if (accept_i) begin
        valid_q <= 1'b1;
      end else if (fire) begin
        valid_q <= 1'b0;
      end
      if (fire && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (fire) begin
        left_mark_q <= cur;
        if (emit) begin
          dark_q   <= DARKEST_RESET;
          bright_q <= BRIGHTEST_RESET;
          seen_q   <= 1'b0;
          mis_q    <= '0;
          cnt_q    <= '0;
          long_q   <= RW'(1);
        end else begin
          dark_q   <= dark_d;
          bright_q <= bright_d;
          seen_q   <= pos_q.last_col ? 1'b0 : seen_d;
          mis_q    <= mis_d;
          cnt_q    <= cnt_d;
          long_q   <= long_d;
        end
      end
    end
  end

  assign out_valid_o            = out_valid_q;
  assign darkest_o              = res_dark_q;
  assign brightest_o            = res_bright_q;
  assign asymmetric_rows_o      = res_mis_q;
  assign contrast_pixels_o      = res_cnt_q;
  assign longest_vertical_run_o = res_long_q;

endmodule

### design/image_frame_statistics.sv
// Result timing: a frame's last pixel is registered in the statistics stage and its result
// is then registered on the output, later only while the previous result still waits to be taken.
// Throughput: one pixel per cycle, set by a single read-modify-write pass over the line
// stores each cycle; input ready drops only while a result waits that has not been taken.
// Reset is asynchronous and active low; it clears position, statistics and handshake state.
// The line stores are not cleared and take no clearing pass.
module image_frame_statistics #(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ifs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ifs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [ifs_pkg::PIXEL_W-1:0]      pixel_value_i,
  input  logic                             frame_start_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ifs_pkg::PIXEL_W-1:0]      darkest_o,
  output logic [ifs_pkg::PIXEL_W-1:0]      brightest_o,
  output logic [ifs_pkg::ASYM_W-1:0]       asymmetric_rows_o,
  output logic [ifs_pkg::CONTRAST_W-1:0]   contrast_pixels_o,
  output logic [ifs_pkg::LONGEST_W-1:0]    longest_vertical_run_o
);
  import ifs_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned WCW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HCW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT + 1);

  logic [FWIDTH_W-1:0]  fwidth_q;
  logic [FHEIGHT_W-1:0] fheight_q;
  logic [THRESH_W-1:0]  thresh_q;
  logic [WCW-1:0]       width;
  logic [HCW-1:0]       height;

  logic          accept;
  logic [CW-1:0] scan_x, scan_m;
  ifs_pos_t      scan_pos;

  logic               wr_en, mk_wr_en, mk_wr_mark;
  logic [CW-1:0]      wr_x, mk_wr_addr;
  logic [PIXEL_W-1:0] wr_pixel, pixel_above, pixel_mirror;
  logic [RW-1:0]      wr_run, run_above;
  logic               mark_above;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwidth_q  <= FRAME_WIDTH_RESET;
      fheight_q <= FRAME_HEIGHT_RESET;
      thresh_q  <= THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH: begin
          fwidth_q <= cfg_data_i;
        end
        REG_FRAME_HEIGHT: begin
          fheight_q <= cfg_data_i[FHEIGHT_W-1:0];
        end
        REG_CONTRAST_THRESHOLD: begin
          thresh_q <= cfg_data_i[THRESH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (fwidth_q == '0) begin
      width = WCW'(1);
    end else if (32'(fwidth_q) > MAX_WIDTH) begin
      width = WCW'(MAX_WIDTH);
    end else begin
      width = WCW'(fwidth_q);
    end
    if (fheight_q == '0) begin
      height = HCW'(1);
    end else if (32'(fheight_q) > MAX_HEIGHT) begin
      height = HCW'(MAX_HEIGHT);
    end else begin
      height = HCW'(fheight_q);
    end
  end

  assign accept = in_valid_i && in_ready_o;

  ifs_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .frame_start_i(frame_start_i),
    .width_i      (width),
    .height_i     (height),
    .x_o          (scan_x),
    .mirror_o     (scan_m),
    .pos_o        (scan_pos)
  );

  ifs_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_line_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_x_i      (scan_x),
    .rd_m_i      (scan_m),
    .wr_en_i     (wr_en),
    .wr_x_i      (wr_x),
    .wr_pixel_i  (wr_pixel),
    .wr_run_i    (wr_run),
    .mk_wr_en_i  (mk_wr_en),
    .mk_wr_addr_i(mk_wr_addr),
    .mk_wr_mark_i(mk_wr_mark),
    .pixel_x_o   (pixel_above),
    .run_x_o     (run_above),
    .pixel_m_o   (pixel_mirror),
    .mark_x_o    (mark_above)
  );

  ifs_stats #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_stats (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .accept_i              (accept),
    .x_i                   (scan_x),
    .pixel_i               (pixel_value_i),
    .pos_i                 (scan_pos),
    .threshold_i           (thresh_q),
    .pixel_above_i         (pixel_above),
    .run_above_i           (run_above),
    .pixel_mirror_i        (pixel_mirror),
    .mark_above_i          (mark_above),
    .ready_o               (in_ready_o),
    .wr_en_o               (wr_en),
    .wr_x_o                (wr_x),
    .wr_pixel_o            (wr_pixel),
    .wr_run_o              (wr_run),
    .mk_wr_en_o            (mk_wr_en),
    .mk_wr_addr_o          (mk_wr_addr),
    .mk_wr_mark_o          (mk_wr_mark),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .darkest_o             (darkest_o),
    .brightest_o           (brightest_o),
    .asymmetric_rows_o     (asymmetric_rows_o),
    .contrast_pixels_o     (contrast_pixels_o),
    .longest_vertical_run_o(longest_vertical_run_o)
  );

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled without a pending result");

  a_column_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WCW'(scan_x) < width)
    else $error("column position outside the frame width");

  a_mirror_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_pos.mirror_active |-> (scan_m <= scan_x))
    else $error("mirror pixel lies right of the current pixel");

  a_row_end_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && scan_pos.last_col |=> scan_pos.first_col)
    else $error("row end did not return to the first column");

endmodule

### tb/image_frame_statistics_test.sv
module image_frame_statistics_test;
  import ifs_pkg::*;

  localparam int unsigned MAX_W = 512;
  localparam int unsigned MAX_H = 256;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic [PIXEL_W-1:0]    darkest;
    logic [PIXEL_W-1:0]    brightest;
    logic [ASYM_W-1:0]     asym_rows;
    logic [CONTRAST_W-1:0] contrast_pixels;
    logic [LONGEST_W-1:0]  longest_run;
  } frame_stats_t;

  class frame_stats_tracker;
    logic [FWIDTH_W-1:0]  width_reg;
    logic [FHEIGHT_W-1:0] height_reg;
    logic [THRESH_W-1:0]  thresh_reg;
    logic [PIXEL_W-1:0]   row_store [MAX_W];
    bit                   mark_store [MAX_W];
    int unsigned          run_store [MAX_W];
    int unsigned          col, row, asym_rows, contrast, longest;
    logic [PIXEL_W-1:0]   lo, hi, prev_pix;
    bit                   row_asym, prev_mark;
    frame_stats_t         pending_stats [$];
    int unsigned          errors, frames_checked;

    function new();
      width_reg = FRAME_WIDTH_RESET;
      height_reg = FRAME_HEIGHT_RESET;
      thresh_reg = THRESHOLD_RESET;
      errors = 0;
      frames_checked = 0;
      restart();
    endfunction

    function void restart();
      col = 0;
      row = 0;
      lo = DARKEST_RESET;
      hi = BRIGHTEST_RESET;
      row_asym = 1'b0;
      asym_rows = 0;
      prev_pix = '0;
      prev_mark = 1'b0;
      contrast = 0;
      longest = 1;
    endfunction

    function int unsigned fit(int unsigned v, int unsigned top);
      return (v < 1) ? 1 : ((v > top) ? top : v);
    endfunction

    function bit exceeds(logic [PIXEL_W-1:0] a, logic [PIXEL_W-1:0] b,
                         logic [THRESH_W-1:0] t);
      return ((a > b) ? (a - b) : (b - a)) > t;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FRAME_WIDTH:        width_reg = data[FWIDTH_W-1:0];
        REG_FRAME_HEIGHT:       height_reg = data[FHEIGHT_W-1:0];
        REG_CONTRAST_THRESHOLD: thresh_reg = data[THRESH_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [PIXEL_W-1:0] v, logic start);
      int unsigned w, h, x, y, m, run;
      logic [PIXEL_W-1:0] above, mirror;
      bit dl, da, cur, lm, last_row;
      frame_stats_t r;
      w = fit(32'(width_reg), MAX_W);
      h = fit(32'(height_reg), MAX_H);
      if (start || col >= w || row >= h) restart();
      x = col;
      y = row;
      last_row = (y == h - 1);
      above = (y > 0) ? row_store[x] : '0;
      dl = (x > 0) && exceeds(v, prev_pix, thresh_reg);
      da = (y > 0) && exceeds(v, above, thresh_reg);

      // The pixel above now has all four neighbors known.
      if (y > 0 && (mark_store[x] || da)) contrast++;
      cur = dl || da;
      if (x > 0) begin
        lm = prev_mark || dl;
        mark_store[x - 1] = lm;
        if (last_row && lm) contrast++;
      end
      if (x == w - 1) begin
        mark_store[x] = cur;
        if (last_row && cur) contrast++;
      end
      prev_mark = cur;
      prev_pix = v;

      if (x >= w / 2 && !row_asym) begin
        m = w - 1 - x;
        mirror = (m == x) ? v : row_store[m];
        if (mirror != v) begin
          asym_rows++;
          row_asym = 1'b1;
        end
      end

      run = (y > 0 && above == v) ? run_store[x] + 1 : 1;
      run_store[x] = run;
      if (run > longest) longest = run;
      row_store[x] = v;
      if (v < lo) lo = v;
      if (v > hi) hi = v;

      if (x == w - 1) begin
        row_asym = 1'b0;
        col = 0;
        if (last_row) begin
          r.darkest = lo;
          r.brightest = hi;
          r.asym_rows = ASYM_W'(asym_rows);
          r.contrast_pixels = CONTRAST_W'(contrast);
          r.longest_run = LONGEST_W'(longest);
          pending_stats.push_back(r);
          restart();
        end else begin
          row = y + 1;
        end
      end else begin
        col = x + 1;
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_stats(logic [PIXEL_W-1:0] dk, logic [PIXEL_W-1:0] br,
                              logic [ASYM_W-1:0] asym, logic [CONTRAST_W-1:0] cp,
                              logic [LONGEST_W-1:0] lr);
      frame_stats_t want;
      if (pending_stats.size() == 0) begin
        $error("frame statistics transfer with no completed frame waiting");
        errors++;
        return;
      end
      want = pending_stats.pop_front();
      frames_checked++;
      compare_field("darkest", 32'(want.darkest), 32'(dk));
      compare_field("brightest", 32'(want.brightest), 32'(br));
      compare_field("asymmetric_rows", 32'(want.asym_rows), 32'(asym));
      compare_field("contrast_pixels", 32'(want.contrast_pixels), 32'(cp));
      compare_field("longest_vertical_run", 32'(want.longest_run), 32'(lr));
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [PIXEL_W-1:0]    pixel_value_i;
  logic                  frame_start_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [PIXEL_W-1:0]    darkest_o;
  logic [PIXEL_W-1:0]    brightest_o;
  logic [ASYM_W-1:0]     asymmetric_rows_o;
  logic [CONTRAST_W-1:0] contrast_pixels_o;
  logic [LONGEST_W-1:0]  longest_vertical_run_o;

  frame_stats_tracker stats;
  int unsigned send_idle_pct = 6;
  int unsigned recv_idle_pct = 54;
  int unsigned quiet_cycles = 0;
  int unsigned items_sent = 0;
  bit need_start = 1'b1;

  image_frame_statistics dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_data_i             (cfg_data_i),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .pixel_value_i          (pixel_value_i),
    .frame_start_i          (frame_start_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .darkest_o              (darkest_o),
    .brightest_o            (brightest_o),
    .asymmetric_rows_o      (asymmetric_rows_o),
    .contrast_pixels_o      (contrast_pixels_o),
    .longest_vertical_run_o (longest_vertical_run_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) stats.note_pixel(pixel_value_i, frame_start_i);
      if (out_valid_o && out_ready_i) begin
        stats.check_stats(darkest_o, brightest_o, asymmetric_rows_o, contrast_pixels_o,
                          longest_vertical_run_o);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_pixel(input logic [PIXEL_W-1:0] v, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_value_i <= v;
    frame_start_i <= start;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (stats.pending_stats.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    stats.set_register(idx, data);
  endtask

  task automatic configure(input int unsigned w, input int unsigned h, input int unsigned t);
    settle();
    write_register(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_register(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    write_register(REG_CONTRAST_THRESHOLD, CFG_DATA_W'(t));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_frame(input int unsigned fw, input int unsigned fh, input bit with_start,
                            input bit noisy);
    logic [PIXEL_W-1:0] row_buf [MAX_W];
    logic [PIXEL_W-1:0] col_base [MAX_W];
    logic [PIXEL_W-1:0] lvl_a, lvl_b;
    int unsigned style, cut, sent;
    bit first;
    style = $urandom_range(4);
    lvl_a = PIXEL_W'($urandom);
    lvl_b = PIXEL_W'($urandom);
    cut = fw * fh;
    if (noisy && $urandom_range(99) < 5) cut = $urandom_range(fw * fh - 1);
    sent = 0;
    first = with_start || need_start;
    need_start = 1'b0;
    for (int i = 0; i < fw; i++) col_base[i] = PIXEL_W'($urandom);
    for (int y = 0; y < fh; y++) begin
      for (int x = 0; x < fw; x++) begin
        case (style)
          0: row_buf[x] = PIXEL_W'($urandom);
          1: row_buf[x] = $urandom_range(1) ? lvl_a : lvl_b;
          2: row_buf[x] = (x < (fw + 1) / 2) ? ($urandom_range(1) ? lvl_a : PIXEL_W'($urandom))
                                             : row_buf[fw - 1 - x];
          3: row_buf[x] = ($urandom_range(7) == 0) ? lvl_a : col_base[x];
          default: row_buf[x] = lvl_a;
        endcase
      end
      if (style == 2 && $urandom_range(3) == 0) begin
        row_buf[$urandom_range(fw - 1)] = PIXEL_W'($urandom);
      end
      for (int x = 0; x < fw; x++) begin
        if (sent == cut) begin
          need_start = 1'b1;
          return;
        end
        send_pixel(row_buf[x], first || (noisy && $urandom_range(199) == 0));
        first = 1'b0;
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned phase, raw_w, raw_h, fw, fh, thr, frames;
    bit extreme;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_FRAME_WIDTH;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    pixel_value_i = '0;
    frame_start_i = 1'b0;
    stats = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Extreme levels in a 3x2 frame whose rows have an odd middle pixel.
    configure(3, 2, 0);
    send_pixel(8'd0, 1'b1); send_pixel(8'd255, 1'b0); send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0); send_pixel(8'd0, 1'b0); send_pixel(8'd255, 1'b0);
    // The next frame follows without a frame start.
    send_pixel(8'd200, 1'b0); send_pixel(8'd201, 1'b0); send_pixel(8'd202, 1'b0);
    send_pixel(8'd200, 1'b0); send_pixel(8'd9, 1'b0); send_pixel(8'd202, 1'b0);
    // A frame start in the middle of a frame begins it again.
    send_pixel(8'd5, 1'b1); send_pixel(8'd5, 1'b1);
    repeat (5) send_pixel(8'd5, 1'b0);
    // Narrowing and then shortening the frame leaves the position outside it.
    send_pixel(8'd1, 1'b1); send_pixel(8'd2, 1'b0);
    configure(2, 2, 0);
    send_pixel(8'd3, 1'b0); send_pixel(8'd3, 1'b0);
    send_pixel(8'd4, 1'b0); send_pixel(8'd4, 1'b0);
    configure(1, 2, 0);
    send_pixel(8'd9, 1'b1);
    configure(1, 1, 0);
    send_pixel(8'd7, 1'b0);

    phase = 0;
    while (items_sent < 1100) begin
      if (items_sent < 367) begin
        send_idle_pct = 6;
        recv_idle_pct = 54;
      end else if (items_sent < 734) begin
        send_idle_pct = 54;
        recv_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      extreme = 1'b1;
      case (phase)
        1: begin raw_w = 0;    raw_h = 0;   thr = 255; fw = 1;   fh = 1;   frames = 8; end
        4: begin raw_w = 1023; raw_h = 0;   thr = 0;   fw = 512; fh = 1;   frames = 1; end
        7: begin raw_w = 0;    raw_h = 511; thr = 255; fw = 1;   fh = 256; frames = 1; end
        10: begin raw_w = 2;   raw_h = 256; thr = 128; fw = 2;   fh = 256; frames = 1; end
        default: begin
          extreme = 1'b0;
          fw = ($urandom_range(9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 24);
          fh = $urandom_range(1, 6);
          raw_w = fw;
          raw_h = fh;
          case ($urandom_range(3))
            0: thr = 0;
            1: thr = 255;
            2: thr = $urandom_range(20);
            default: thr = $urandom_range(255);
          endcase
          frames = $urandom_range(2, 5);
        end
      endcase
      configure(raw_w, raw_h, thr);
      need_start = 1'b1;
      for (int f = 0; f < frames; f++) send_frame(fw, fh, $urandom_range(1), !extreme);
      phase++;
    end

    settle();
    if (stats.errors == 0 && stats.pending_stats.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
